FILE: src/ppe_pkg.sv
// Shared constants, types and fixed-point helpers of the piecewise Pade evaluator.
package ppe_pkg;

  localparam int NUM_DEGREE  = 3;
  localparam int DEN_DEGREE  = 2;
  localparam int TABLE_DEPTH = 1024;
  localparam int SLOTS       = NUM_DEGREE + DEN_DEGREE + 1;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W     = 10;
  localparam int SLOT_W      = 4;
  // Horner chain length, the shorter polynomial is padded with leading zeros
  localparam int HORNER_LEN  = ((NUM_DEGREE > DEN_DEGREE) ? NUM_DEGREE : DEN_DEGREE) + 1;
  // quotient bits: a 32-bit magnitude shifted up by 16
  localparam int DIV_W       = 48;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic [1:0] REG_MIN_ARG   = 2'd0;
  localparam logic [1:0] REG_STEP_SIZE = 2'd1;
  localparam logic [1:0] REG_INV_STEP  = 2'd2;
  localparam logic [1:0] REG_NUM_INTV  = 2'd3;

  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  typedef struct packed {
    logic signed [31:0] min_arg;
    logic [30:0]        step_size;
    logic [30:0]        inv_step;
    logic [10:0]        num_intervals;
  } ppe_cfg_t;

  // item handed from the front end to the back end
  typedef struct packed {
    logic               kind;
    logic [ENTRY_W-1:0] entry;
    logic [SLOT_W-1:0]  slot;
    logic signed [31:0] coef;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] off;
    logic               oor;
  } ppe_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Q16.16 product: floor shift by 16, then saturate
  function automatic logic signed [31:0] qfix(input logic signed [63:0] p);
    logic signed [65:0] w;
    w = {{2{p[63]}}, p};
    return sat32(w >>> 16);
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [65:0] w;
    w = {{34{a[31]}}, a} + {{34{b[31]}}, b};
    return sat32(w);
  endfunction

endpackage

FILE: src/ppe_front.sv
// Front end: accepts items, finds the grid index and the offset from the grid point.
module ppe_front import ppe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppe_cfg_t           cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_kind_i,
  input  logic [ENTRY_W-1:0] in_entry_i,
  input  logic [SLOT_W-1:0]  in_slot_i,
  input  logic signed [31:0] in_coef_i,
  input  logic signed [31:0] in_x_i,
  output logic               push_o,
  output ppe_item_t          item_o,
  input  logic               full_i
);

  typedef struct packed {
    logic               kind;
    logic [ENTRY_W-1:0] entry;
    logic [SLOT_W-1:0]  slot;
    logic signed [31:0] coef;
  } ld_t;

  logic fen;
  logic v1_q, v2_q, v3_q, v4_q;
  ld_t  ld1_q, ld2_q, ld3_q, ld4_q;
  logic signed [32:0] dx1_q, dx2_q, dx3_q, dx4_q;
  logic signed [63:0] t2_q;
  logic [IDX_W-1:0]   idx3_q, idx4_q;
  logic               oor3_q, oor4_q;
  logic [IDX_W+30:0]  prod4_q;

  logic signed [32:0] dx_w;
  logic signed [64:0] mul_w;
  logic signed [64:0] s_w;
  logic [31:0]        hi_w;
  logic [16:0]        lim_w;
  logic [IDX_W-1:0]   lim_m1;
  logic [IDX_W-1:0]   idx_w;
  logic               oor_w;
  logic [IDX_W+30:0]  prod_w;

  // whole front stalls only when its last stage cannot enter the queue
  assign fen        = !(v4_q && full_i);
  assign in_ready_o = fen;
  assign push_o     = v4_q && !full_i;

  assign dx_w   = {in_x_i[31], in_x_i} - {cfg_i.min_arg[31], cfg_i.min_arg};
  assign mul_w  = dx1_q * $signed({1'b0, cfg_i.inv_step});
  assign prod_w = idx3_q * cfg_i.step_size;

  // usable table limit
  always_comb begin
    if (cfg_i.num_intervals == 11'd0) begin
      lim_w = 17'd1;
    end else if ({6'b0, cfg_i.num_intervals} > 17'(TABLE_DEPTH)) begin
      lim_w = 17'(TABLE_DEPTH);
    end else begin
      lim_w = {6'b0, cfg_i.num_intervals};
    end
    lim_m1 = IDX_W'(lim_w - 17'd1);
  end

  // round to the nearest grid point and clamp
  always_comb begin
    s_w  = {t2_q[63], t2_q} + 65'sh0_8000_0000;
    hi_w = s_w[63:32];
    if (s_w[64]) begin
      idx_w = '0;
      oor_w = 1'b1;
    end else if (hi_w > 32'(lim_m1)) begin
      idx_w = lim_m1;
      oor_w = 1'b1;
    end else begin
      idx_w = hi_w[IDX_W-1:0];
      oor_w = 1'b0;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (fen) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (fen) begin
      ld1_q   <= '{kind: in_kind_i, entry: in_entry_i, slot: in_slot_i, coef: in_coef_i};
      dx1_q   <= dx_w;
      ld2_q   <= ld1_q;
      dx2_q   <= dx1_q;
      t2_q    <= mul_w[63:0];
      ld3_q   <= ld2_q;
      dx3_q   <= dx2_q;
      idx3_q  <= idx_w;
      oor3_q  <= oor_w;
      ld4_q   <= ld3_q;
      dx4_q   <= dx3_q;
      idx4_q  <= idx3_q;
      oor4_q  <= oor3_q;
      prod4_q <= prod_w;
    end
  end

  always_comb begin
    item_o.kind  = ld4_q.kind;
    item_o.entry = ld4_q.entry;
    item_o.slot  = ld4_q.slot;
    item_o.coef  = ld4_q.coef;
    item_o.idx   = idx4_q;
    item_o.oor   = oor4_q;
    item_o.off   = sat32({{33{dx4_q[32]}}, dx4_q} - {{(35 - IDX_W){1'b0}}, prod4_q});
  end

endmodule

FILE: src/ppe_fifo.sv
// Short queue between the front end and the back end.
module ppe_fifo import ppe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ppe_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output ppe_item_t item_o,
  output logic      empty_o
);

  ppe_item_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= item_i;
  end

endmodule

FILE: src/ppe_back.sv
// Back end: coefficient banks, Horner pipelines, restoring divider, output register.
module ppe_back import ppe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ppe_item_t          item_i,
  output logic               pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic signed [31:0] result_o,
  output logic               oor_o,
  output logic               pole_o
);

  typedef logic [SLOTS-1:0][31:0] coefs_t;

  // coefficient for Horner step j of the numerator, leading zeros pad
  function automatic logic signed [31:0] coef_p(input coefs_t c, input int j);
    int k;
    k = j - (HORNER_LEN - 1 - NUM_DEGREE);
    if (k < 0) return '0;
    return c[NUM_DEGREE - k];
  endfunction

  // denominator: leading zeros pad, then q_N .. q_1, then the implied constant one
  function automatic logic signed [31:0] coef_q(input coefs_t c, input int j);
    int k;
    k = DEN_DEGREE - (j - (HORNER_LEN - 1 - DEN_DEGREE));
    if (k > DEN_DEGREE) return '0;
    if (k == 0) return ONE_Q16;
    return c[NUM_DEGREE + k];
  endfunction

  logic en;
  logic wr_en;
  coefs_t rd_q;

  logic               sv_q   [HORNER_LEN];
  logic signed [31:0] soff_q [HORNER_LEN];
  logic               soor_q [HORNER_LEN];
  coefs_t             scoef  [HORNER_LEN];
  coefs_t             scoef_q[1:HORNER_LEN-1];
  logic signed [63:0] sp_q   [1:HORNER_LEN-1];
  logic signed [63:0] sq_q   [1:HORNER_LEN-1];
  logic signed [31:0] curp   [HORNER_LEN];
  logic signed [31:0] curq   [HORNER_LEN];

  logic               fv_q, foor_q;
  logic signed [31:0] fp_q, fq_q;

  logic               dv_q   [DIV_W+1];
  logic [31:0]        drem   [DIV_W+1];
  logic [DIV_W-1:0]   dnq    [DIV_W+1];
  logic [31:0]        dd     [DIV_W+1];
  logic               dneg   [DIV_W+1];
  logic               dpole  [DIV_W+1];
  logic               door   [DIV_W+1];

  logic               ov_q;
  logic signed [31:0] ores_q;
  logic               ooor_q, opole_q;
  logic signed [31:0] res_w;
  logic [31:0]        absp_w, absq_w;
  logic [DIV_W-1:0]   quot_w;

  // everything behind the queue advances together
  assign en    = !ov_q || res_ready_i;
  assign pop_o = valid_i && en;
  assign wr_en = pop_o && (item_i.kind == KIND_LOAD)
                 && ({1'b0, item_i.entry} < 11'(TABLE_DEPTH))
                 && (item_i.slot < SLOT_W'(SLOTS));

  // one bank per slot, so a whole entry is read at once
  for (genvar s = 0; s < SLOTS; s++) begin : g_bank
    logic [31:0] bank [TABLE_DEPTH];
    always_ff @(posedge clk_i) begin
      if (wr_en && (item_i.slot == SLOT_W'(s))) begin
        bank[item_i.entry[IDX_W-1:0]] <= item_i.coef;
      end
      if (en) rd_q[s] <= bank[item_i.idx];
    end
  end

  // stage zero: table read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= valid_i && (item_i.kind == KIND_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      soff_q[0] <= item_i.off;
      soor_q[0] <= item_i.oor;
    end
  end

  assign scoef[0] = rd_q;
  assign curp[0]  = coef_p(rd_q, 0);
  assign curq[0]  = coef_q(rd_q, 0);

  // Horner steps: multiply, then shift, saturate and add the next coefficient
  for (genvar m = 1; m < HORNER_LEN; m++) begin : g_horner
    assign scoef[m] = scoef_q[m];
    assign curp[m]  = sat_add(qfix(sp_q[m]), coef_p(scoef_q[m], m));
    assign curq[m]  = sat_add(qfix(sq_q[m]), coef_q(scoef_q[m], m));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[m] <= 1'b0;
      end else if (en) begin
        sv_q[m] <= sv_q[m-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sp_q[m]    <= soff_q[m-1] * curp[m-1];
        sq_q[m]    <= soff_q[m-1] * curq[m-1];
        soff_q[m]  <= soff_q[m-1];
        soor_q[m]  <= soor_q[m-1];
        scoef_q[m] <= scoef[m-1];
      end
    end
  end

  // finished P and Q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (en) begin
      fv_q <= sv_q[HORNER_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fp_q   <= curp[HORNER_LEN-1];
      fq_q   <= curq[HORNER_LEN-1];
      foor_q <= soor_q[HORNER_LEN-1];
    end
  end

  // divider entry: magnitudes, sign and pole check
  assign absp_w   = fp_q[31] ? 32'(-fp_q) : 32'(fp_q);
  assign absq_w   = fq_q[31] ? 32'(-fq_q) : 32'(fq_q);
  assign dv_q[0]  = fv_q;
  assign drem[0]  = '0;
  assign dnq[0]   = {absp_w, 16'b0};
  assign dpole[0] = (fq_q == '0);
  assign dd[0]    = dpole[0] ? 32'd1 : absq_w;
  assign dneg[0]  = fp_q[31] ^ fq_q[31];
  assign door[0]  = foor_q;

  // restoring divider, one quotient bit per stage
  for (genvar i = 1; i <= DIV_W; i++) begin : g_div
    logic [32:0] t_w;
    logic        ge_w;
    logic        v_q;
    logic [31:0] rem_q, d_q;
    logic [DIV_W-1:0] nq_q;
    logic        neg_q, pole_q, oor_q;

    assign t_w  = {drem[i-1], dnq[i-1][DIV_W-1]};
    assign ge_w = (t_w >= {1'b0, dd[i-1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= dv_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q  <= ge_w ? 32'(t_w - {1'b0, dd[i-1]}) : t_w[31:0];
        nq_q   <= {dnq[i-1][DIV_W-2:0], ge_w};
        d_q    <= dd[i-1];
        neg_q  <= dneg[i-1];
        pole_q <= dpole[i-1];
        oor_q  <= door[i-1];
      end
    end

    assign dv_q[i]  = v_q;
    assign drem[i]  = rem_q;
    assign dnq[i]   = nq_q;
    assign dd[i]    = d_q;
    assign dneg[i]  = neg_q;
    assign dpole[i] = pole_q;
    assign door[i]  = oor_q;
  end

  // sign and saturation of the quotient
  assign quot_w = dnq[DIV_W];
  always_comb begin
    if (dpole[DIV_W]) begin
      res_w = '0;
    end else if (dneg[DIV_W]) begin
      if (quot_w > DIV_W'(32'h8000_0000)) res_w = 32'sh8000_0000;
      else res_w = 32'(-quot_w[31:0]);
    end else begin
      if (quot_w > DIV_W'(32'h7FFF_FFFF)) res_w = 32'sh7FFF_FFFF;
      else res_w = quot_w[31:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= dv_q[DIV_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ores_q  <= res_w;
      ooor_q  <= door[DIV_W];
      opole_q <= dpole[DIV_W];
    end
  end

  assign res_valid_o = ov_q;
  assign result_o    = ores_q;
  assign oor_o       = ooor_q;
  assign pole_o      = opole_q;

endmodule

FILE: src/piecewise_pade_evaluator.sv
// Top level of the piecewise Pade evaluator: register port, front end, queue, back end.
//
// Takes one item per clock cycle while nothing downstream stalls. A load transfer
// writes one coefficient word and yields no result; an evaluate transfer yields one
// result after 4 front stages, the queue, 1 table read stage, HORNER_LEN-1 multiply
// stages, 1 stage for P and Q, DIV_W (48) divider stages and the output register. The
// rate is set by the fully pipelined Horner chains and the one-bit-per-stage restoring
// divider. The coefficient table needs no clearing; every entry used must be loaded
// first. The user must write registers only while idle; the block does not enforce it.
module piecewise_pade_evaluator import ppe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // entry_index[9:0], coef_slot[13:10],
                                     // coef_value[45:14], x_value[77:46], zero
  input  logic        s_axis_tuser,  // kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_value
  output logic [1:0]  m_axis_tuser   // out_of_range[0], pole_hit[1]
);

  ppe_cfg_t  cfg_q;
  logic      push, full, empty, pop;
  ppe_item_t f_item, q_item;
  logic signed [31:0] res;
  logic      oor, pole;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_arg       <= '0;
      cfg_q.step_size     <= 31'd65536;
      cfg_q.inv_step      <= 31'd65536;
      cfg_q.num_intervals <= 11'd1024;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MIN_ARG:   cfg_q.min_arg       <= pwdata;
        REG_STEP_SIZE: cfg_q.step_size     <= pwdata[30:0];
        REG_INV_STEP:  cfg_q.inv_step      <= pwdata[30:0];
        REG_NUM_INTV:  cfg_q.num_intervals <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_MIN_ARG:   prdata = cfg_q.min_arg;
      REG_STEP_SIZE: prdata = {1'b0, cfg_q.step_size};
      REG_INV_STEP:  prdata = {1'b0, cfg_q.inv_step};
      REG_NUM_INTV:  prdata = {21'b0, cfg_q.num_intervals};
      default:       prdata = '0;
    endcase
  end

  ppe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_entry_i (s_axis_tdata[9:0]),
    .in_slot_i  (s_axis_tdata[13:10]),
    .in_coef_i  (s_axis_tdata[45:14]),
    .in_x_i     (s_axis_tdata[77:46]),
    .push_o     (push),
    .item_o     (f_item),
    .full_i     (full)
  );

  ppe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (q_item),
    .empty_o (empty)
  );

  ppe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (!empty),
    .item_i      (q_item),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .result_o    (res),
    .oor_o       (oor),
    .pole_o      (pole)
  );

  assign m_axis_tdata = res;
  assign m_axis_tuser = {pole, oor};

endmodule

FILE: src/ppe_checker.sv
// Port-level checks of the piecewise Pade evaluator, bound to the top level.
module ppe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        pready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a pole always gives a zero result
  a_pole_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 32'd0)
    else $error("pole with nonzero result");

  // a sampled reset clears the result valid
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result during reset");

  // register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("pready low");

endmodule

bind piecewise_pade_evaluator ppe_checker u_ppe_checker (.*);

FILE: test/piecewise_pade_evaluator_test.sv
// Self-checking testbench of the piecewise Pade evaluator: table loads, evaluations, registers.
`timescale 1ns / 100ps

module piecewise_pade_evaluator_test;
  import ppe_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int PHASE_ITEMS    = 80;

  typedef struct {
    logic [31:0] res;
    logic        oor;
    logic        pole;
  } pade_result_t;

  // one row of the directed part; has_exp marks a typed-in expected result
  typedef struct {
    logic        kind;
    int          entry;
    int          slot;
    logic [31:0] coef;
    logic [31:0] x;
    bit          has_exp;
    logic [31:0] res;
    bit          oor;
    bit          pole;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // entry_index, coef_slot, coef_value, x_value, zero
  logic        s_axis_tuser = 1'b0;  // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // result_value
  logic [1:0]  m_axis_tuser;  // out_of_range, pole_hit

  piecewise_pade_evaluator DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // predictor state: registers and coefficient table
  longint cfg_min, cfg_step, cfg_inv;
  int     cfg_nint;
  logic signed [31:0]   coef_mem [TABLE_DEPTH*SLOTS];
  logic [SLOTS-1:0]     slot_written [TABLE_DEPTH];

  pade_result_t results_due[$];
  pade_result_t head_res;
  bit  idle_on = 1'b1;
  int  mismatches = 0;
  int  n_loads = 0, n_evals = 0, n_results = 0, n_oor = 0, n_poles = 0;
  int  quiet_cycles = 0;
  int  sink_hold = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qprod(longint a, longint b);
    return clip32((a * b) >>> 16);
  endfunction

  // grid point nearest to x, with clamping, and the offset from it
  function automatic void locate_grid(logic [31:0] x, output int idx, output bit oor,
                                      output longint off);
    longint lim, dx, s;
    lim = (cfg_nint == 0) ? 1 : (cfg_nint > TABLE_DEPTH) ? TABLE_DEPTH : cfg_nint;
    dx = longint'($signed(x)) - cfg_min;
    s = dx * cfg_inv + 64'sd2147483648;
    oor = 1'b0;
    if (s < 0) begin
      idx = 0;
      oor = 1'b1;
    end else if ((s >>> 32) > lim - 1) begin
      idx = int'(lim - 1);
      oor = 1'b1;
    end else begin
      idx = int'(s >>> 32);
    end
    off = clip32(dx - longint'(idx) * cfg_step);
  endfunction

  function automatic pade_result_t evaluate_pade(logic [31:0] x);
    pade_result_t r;
    int idx, base;
    bit oor;
    longint off, p, q;
    locate_grid(x, idx, oor, off);
    base = idx * SLOTS;
    p = qprod(off, coef_mem[base + NUM_DEGREE]);
    for (int k = NUM_DEGREE - 1; k > 0; k--)
      p = qprod(off, clip32(longint'(coef_mem[base + k]) + p));
    p = clip32(p + coef_mem[base]);
    q = qprod(off, coef_mem[base + NUM_DEGREE + DEN_DEGREE]);
    for (int k = DEN_DEGREE - 1; k > 0; k--)
      q = qprod(off, clip32(longint'(coef_mem[base + NUM_DEGREE + k]) + q));
    q = clip32(q + 65536);
    r.oor = oor;
    r.pole = (q == 0);
    r.res = (q == 0) ? 32'd0 : 32'(clip32((p * 65536) / q));
    return r;
  endfunction

  // one transfer on the input stream; table and expectations follow on acceptance
  task automatic send_item(logic kind, int entry, int slot, logic [31:0] coef,
                           logic [31:0] x, bit typed = 1'b0, pade_result_t typed_res = '{0, 0, 0});
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, x, coef, slot[SLOT_W-1:0], entry[ENTRY_W-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind == KIND_LOAD) begin
      n_loads++;
      if (entry < TABLE_DEPTH && slot < SLOTS) begin
        coef_mem[entry*SLOTS + slot] = coef;
        slot_written[entry][slot] = 1'b1;
      end
    end else begin
      n_evals++;
      results_due.push_back(typed ? typed_res : evaluate_pade(x));
    end
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MIN_ARG:   cfg_min = longint'($signed(v));
      REG_STEP_SIZE: cfg_step = longint'(v[30:0]);
      REG_INV_STEP:  cfg_inv = longint'(v[30:0]);
      REG_NUM_INTV:  cfg_nint = int'(v[10:0]);
      default: ;
    endcase
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_coef();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 524288)) - 262144);
  endfunction

  // random evaluation; loads a whole entry first when it has not been filled
  task automatic random_eval();
    logic [31:0] x;
    int idx, k;
    bit oor;
    longint off;
    if ($urandom_range(0, 3) == 0) begin
      x = $urandom();
    end else begin
      k = $urandom_range(0, cfg_nint + 3) - 2;
      x = 32'(clip32(cfg_min + longint'(k) * cfg_step
                     + longint'($urandom_range(0, 65536)) - 32768));
    end
    locate_grid(x, idx, oor, off);
    if (slot_written[idx] != '1)
      for (int s = 0; s < SLOTS; s++) send_item(KIND_LOAD, idx, s, random_coef(), $urandom());
    send_item(KIND_EVAL, $urandom_range(0, 1023), $urandom_range(0, 15), $urandom(), x);
  endtask

  directed_row_t directed_rows[] = '{
    // entry 0: constant 2.0
    '{KIND_LOAD, 0, 0, 32'h0002_0000, 0, 0, 0, 0, 0},
    '{KIND_LOAD, 0, 1, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_LOAD, 0, 2, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_LOAD, 0, 3, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_LOAD, 0, 4, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_LOAD, 0, 5, 32'h0, 0, 0, 0, 0, 0},
    // entry 1: largest numerator over 1 - 4*dx
    '{KIND_LOAD, 1, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
    '{KIND_LOAD, 1, 1, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_LOAD, 1, 2, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_LOAD, 1, 3, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_LOAD, 1, 4, 32'hFFFC_0000, 0, 0, 0, 0, 0},
    '{KIND_LOAD, 1, 5, 32'h0, 0, 0, 0, 0, 0},
    // slot out of bounds: ignored
    '{KIND_LOAD, 0, 15, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0},
    '{KIND_LOAD, 1023, 6, 32'h8000_0000, 0, 0, 0, 0, 0},
    '{KIND_LOAD, 1023, 8, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
    '{KIND_EVAL, 0, 0, 0, 32'h0000_0000, 1, 32'h0002_0000, 0, 0},
    '{KIND_EVAL, 1023, 15, 32'hFFFF_FFFF, 32'h8000_0000, 1, 32'h0002_0000, 1, 0},
    '{KIND_EVAL, 0, 0, 0, 32'h0001_4000, 1, 32'h0, 0, 1},
    '{KIND_EVAL, 0, 0, 0, 32'h0001_2000, 1, 32'h7FFF_FFFF, 0, 0},
    '{KIND_EVAL, 0, 0, 0, 32'h0000_4000, 0, 0, 0, 0}
  };

  // register settings per random phase: min_arg, step_size, inv_step, num_intervals
  logic [31:0] phase_cfg[6][4] = '{
    '{32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'd1024},
    '{32'hFFFD_0000, 32'h0000_8000, 32'h0002_0000, 32'd8},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'd1},
    '{32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'd0},
    '{32'h0000_0000, 32'h0000_4000, 32'h0004_0000, 32'd2047},
    '{32'hFFFF_8000, 32'h0000_C000, 32'h0001_5555, 32'd5}
  };

  // sink side: ready with random stall bursts while idle_on is set
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      sink_hold <= $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %h/%b with no evaluation pending", m_axis_tdata, m_axis_tuser);
      end else begin
        head_res = results_due.pop_front();
        n_oor += head_res.oor;
        n_poles += head_res.pole;
        if (head_res.res !== m_axis_tdata || head_res.oor !== m_axis_tuser[0] ||
            head_res.pole !== m_axis_tuser[1]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h oor %b pole %b, got %h oor %b pole %b",
                     head_res.res, head_res.oor, head_res.pole,
                     m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int phase_start;
    cfg_min = 0;
    cfg_step = 65536;
    cfg_inv = 65536;
    cfg_nint = 1024;
    foreach (slot_written[i]) slot_written[i] = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings
    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].entry, directed_rows[i].slot,
                directed_rows[i].coef, directed_rows[i].x, directed_rows[i].has_exp,
                '{directed_rows[i].res, directed_rows[i].oor, directed_rows[i].pole});

    // random phases, each under its own register setting; loads that fill
    // an entry count toward the phase's transfers
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_settle();
      for (int r = 0; r < 4; r++) reg_write(2'(r), phase_cfg[ph][r]);
      if (ph == 5) idle_on = 1'b0;
      phase_start = n_loads + n_evals;
      while (n_loads + n_evals - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0)
          send_item(KIND_LOAD, $urandom_range(0, 1023), $urandom_range(0, 15),
                    random_coef(), $urandom());
        else
          random_eval();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d loads and %0d evaluations over 6 register settings", n_loads,
             n_evals);
    $display("%0d results checked, %0d clamped, %0d poles, %0d mismatches", n_results,
             n_oor, n_poles, mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
